>>> hdl/gfbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbd_pkg
// shared types, widths and constants of the gated frequency band detector
// ----------------------------------------------------------------------------
package gfbd_pkg;

    localparam int STEP_BITS      = 10;
    localparam int EDGE_BITS      = 4;
    localparam int HZ_BITS        = 25;
    localparam int GATE_BITS      = 10;
    localparam int COUNT_BITS     = 15;
    localparam int ELAPSED_BITS   = 24;
    localparam int COUNT_LIMIT    = 30000;
    localparam int SCALE_BITS     = 20;
    localparam int GATE_US_BITS   = GATE_BITS + 10;
    localparam int NUM_BITS       = COUNT_BITS + SCALE_BITS;
    localparam int DIV_CNT_BITS   = $clog2(NUM_BITS);
    localparam int US_PER_S       = 1000000;
    localparam int US_PER_MS      = 1000;
    localparam int HZ_MAX         = 30000000;
    localparam int JOB_DEPTH      = 2;
    localparam int JOB_AW         = $clog2(JOB_DEPTH);
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 25;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GATE_TIME_MS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_MIN_HZ   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_MAX_HZ   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_MIN_HZ  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_MAX_HZ  = 3'd5;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_us;
        logic [EDGE_BITS-1:0] edge_count;
        logic                 switch_high;
    } t_in_item;

    typedef struct packed {
        logic [HZ_BITS-1:0] frequency_hz;
        logic               low_band;
        logic               beacon_detected;
        logic               switch_level;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0]   pulse_total;
        logic [ELAPSED_BITS-1:0] elapsed_us;
        logic                    switch_high;
    } t_job;

    typedef struct packed {
        logic                 enable;
        logic [GATE_BITS-1:0] gate_time_ms;
        logic [HZ_BITS-1:0]   low_min_hz;
        logic [HZ_BITS-1:0]   low_max_hz;
        logic [HZ_BITS-1:0]   high_min_hz;
        logic [HZ_BITS-1:0]   high_max_hz;
    } t_cfg;

endpackage

>>> hdl/gfbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbd_front
// accumulates edges and gate time per item, hands finished gates to the queue
// ----------------------------------------------------------------------------
module gfbd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gfbd_pkg::t_in_item i_item,
    input  gfbd_pkg::t_cfg   i_cfg,
    input  logic             i_job_full,
    output logic             o_job_push,
    output gfbd_pkg::t_job   o_job
);
    import gfbd_pkg::*;

    logic [COUNT_BITS-1:0]   r_pulse;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [COUNT_BITS-1:0]   n_pulse;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic [COUNT_BITS:0]     pulse_sum;
    logic [ELAPSED_BITS:0]   elapsed_sum;
    logic [GATE_US_BITS-1:0] gate_us;
    logic                    accept;
    logic                    gate_end;

    assign accept = i_push && !i_job_full;

    always_comb begin
        pulse_sum   = {1'b0, r_pulse} + (COUNT_BITS+1)'(i_item.edge_count);
        elapsed_sum = {1'b0, r_elapsed} + (ELAPSED_BITS+1)'(i_item.step_us);
        if (pulse_sum > (COUNT_BITS+1)'(COUNT_LIMIT)) begin
            n_pulse = COUNT_BITS'(COUNT_LIMIT);
        end else begin
            n_pulse = pulse_sum[COUNT_BITS-1:0];
        end
        if (elapsed_sum[ELAPSED_BITS]) begin
            n_elapsed = '1;
        end else begin
            n_elapsed = elapsed_sum[ELAPSED_BITS-1:0];
        end
        gate_us  = GATE_US_BITS'(i_cfg.gate_time_ms) * GATE_US_BITS'(US_PER_MS);
        gate_end = i_cfg.enable && (n_elapsed >= ELAPSED_BITS'(gate_us));
    end

    assign o_job_push        = accept && gate_end;
    assign o_job.pulse_total = n_pulse;
    assign o_job.elapsed_us  = n_elapsed;
    assign o_job.switch_high = i_item.switch_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse   <= '0;
            r_elapsed <= '0;
        end else if (accept) begin
            if (gate_end) begin
                r_pulse   <= '0;
                r_elapsed <= '0;
            end else begin
                r_pulse   <= n_pulse;
                r_elapsed <= n_elapsed;
            end
        end
    end

endmodule

>>> hdl/gfbd_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbd_job_queue
// short queue of finished gates between front and back
// ----------------------------------------------------------------------------
module gfbd_job_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gfbd_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output gfbd_pkg::t_job o_data
);
    import gfbd_pkg::*;

    t_job              r_mem [JOB_DEPTH];
    logic [JOB_AW-1:0] r_wr_ptr;
    logic [JOB_AW-1:0] r_rd_ptr;
    logic [JOB_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (JOB_AW+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == JOB_AW'(JOB_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == JOB_AW'(JOB_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/gfbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbd_back
// scales the edge count, divides by the elapsed time, saturates and checks the window
// ----------------------------------------------------------------------------
module gfbd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  gfbd_pkg::t_job    i_job,
    output logic              o_job_pop,
    input  gfbd_pkg::t_cfg    i_cfg,
    input  logic              i_pop,
    output logic              o_empty,
    output gfbd_pkg::t_out_item o_item
);
    import gfbd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_FIN
    } t_state;

    t_state                  r_state;
    logic [COUNT_BITS-1:0]   r_count;
    logic [ELAPSED_BITS-1:0] r_div;
    logic                    r_sw;
    logic [NUM_BITS-1:0]     r_quo;
    logic [ELAPSED_BITS-1:0] r_rem;
    logic [DIV_CNT_BITS-1:0] r_bit;
    logic [HZ_BITS-1:0]      r_hz;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic [ELAPSED_BITS:0]   trial;
    logic                    trial_ge;
    logic [ELAPSED_BITS:0]   trial_diff;
    logic [HZ_BITS-1:0]      win_lo;
    logic [HZ_BITS-1:0]      win_hi;
    logic                    out_free;

    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;
    assign out_free  = !r_out_valid || i_pop;

    always_comb begin
        trial      = {r_rem, r_quo[NUM_BITS-1]};
        trial_ge   = trial >= {1'b0, r_div};
        trial_diff = trial - {1'b0, r_div};
        win_lo     = r_sw ? i_cfg.low_min_hz  : i_cfg.high_min_hz;
        win_hi     = r_sw ? i_cfg.low_max_hz  : i_cfg.high_max_hz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in the finishing state a popped item is replaced right away
            if (i_pop && r_out_valid && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_count <= i_job.pulse_total;
                        r_div   <= i_job.elapsed_us;
                        r_sw    <= i_job.switch_high;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_quo   <= NUM_BITS'(r_count) * NUM_BITS'(US_PER_S);
                    r_rem   <= '0;
                    r_bit   <= DIV_CNT_BITS'(NUM_BITS-1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= trial_ge ? trial_diff[ELAPSED_BITS-1:0]
                                      : trial[ELAPSED_BITS-1:0];
                    r_quo <= {r_quo[NUM_BITS-2:0], trial_ge};
                    if (r_bit == '0) begin
                        r_state <= ST_SAT;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                ST_SAT: begin
                    if (r_div == '0) begin
                        r_hz <= '0;
                    end else if (r_quo > NUM_BITS'(HZ_MAX)) begin
                        r_hz <= HZ_BITS'(HZ_MAX);
                    end else begin
                        r_hz <= r_quo[HZ_BITS-1:0];
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out.frequency_hz    <= r_hz;
                        r_out.low_band        <= r_sw;
                        r_out.beacon_detected <= (r_hz >= win_lo) && (r_hz <= win_hi);
                        r_out.switch_level    <= r_sw;
                        r_out_valid           <= 1'b1;
                        r_state               <= ST_IDLE;
                    end else if (i_pop && r_out_valid) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/gated_frequency_band_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_frequency_band_detector
// gated edge counter that reports frequency in hertz and a band window match
// ----------------------------------------------------------------------------
// The block takes one time-base item per clock cycle: push is accepted in any
// cycle where full is low, and full rises only while two finished gates are
// still waiting for the divider. Every item adds its microseconds and edges to
// the gate counters; when enabled and the gate time is reached, the totals
// go into a two-entry job queue and the counters clear. The back end works
// on one gate at a time (taking the job, one scaling multiply, a 35-step
// bit-serial restoring divide, saturation, window compare) and takes the
// next job only once the last result is written, so gates that end faster
// than it finishes fill the queue and stall the input. The result sits in
// an output register until popped while the front keeps counting.
module gated_frequency_band_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item side
    input  logic                                push,
    output logic                                full,
    input  gfbd_pkg::t_in_item                  i_item,
    // result item side
    output logic                                empty,
    input  logic                                pop,
    output gfbd_pkg::t_out_item                 o_item,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [gfbd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [gfbd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import gfbd_pkg::*;

    t_cfg r_cfg;
    logic job_push;
    t_job job_in;
    logic job_full;
    logic job_pop;
    logic job_empty;
    t_job job_out;

    // configuration registers, plain writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable       <= 1'b0;
            r_cfg.gate_time_ms <= GATE_BITS'(50);
            r_cfg.low_min_hz   <= HZ_BITS'(0);
            r_cfg.low_max_hz   <= HZ_BITS'(4000);
            r_cfg.high_min_hz  <= HZ_BITS'(6000);
            r_cfg.high_max_hz  <= HZ_BITS'(12000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:       r_cfg.enable       <= i_cfg_data[0];
                CFG_GATE_TIME_MS: r_cfg.gate_time_ms <= i_cfg_data[GATE_BITS-1:0];
                CFG_LOW_MIN_HZ:   r_cfg.low_min_hz   <= i_cfg_data[HZ_BITS-1:0];
                CFG_LOW_MAX_HZ:   r_cfg.low_max_hz   <= i_cfg_data[HZ_BITS-1:0];
                CFG_HIGH_MIN_HZ:  r_cfg.high_min_hz  <= i_cfg_data[HZ_BITS-1:0];
                CFG_HIGH_MAX_HZ:  r_cfg.high_max_hz  <= i_cfg_data[HZ_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stalls only when the job queue cannot take a finished gate
    assign full = job_full;

    // front: gate counters and gate-end detection
    gfbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // finished gates waiting for the divider
    gfbd_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    // back: frequency computation and window check, holds the result item
    gfbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_cfg       (r_cfg),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

endmodule

>>> tb/sv/tb_gated_frequency_band_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_frequency_band_detector
// self-checking bench for the gated frequency band detector
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the gate counters and the register
// file and works out the result of every gate an accepted item closes. A short
// directed part hits window bounds, zero elapsed time, saturation of the
// frequency and windows with min above max. Random phases follow with fresh
// settings and different idling patterns, and one disabled stretch builds up
// a long gate that closes right after the block is enabled again.
// ----------------------------------------------------------------------------
module tb_gated_frequency_band_detector;
    import gfbd_pkg::*;

    localparam int CLK_HALF_NS    = 4;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASE_ITEMS    = 160;
    localparam int RANDOM_PHASES  = 10;
    localparam int SAT_ITEMS      = 100;
    localparam longint TIMEOUT_NS = 64'd2000000 * 2 * CLK_HALF_NS;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // ------------------------------------------------------------------------
    // scoreboard: gate counter model plus queue of expected results
    // ------------------------------------------------------------------------
    class band_scoreboard;
        t_cfg                    regs;
        logic [COUNT_BITS-1:0]   pulse_total;
        logic [ELAPSED_BITS-1:0] elapsed_us;
        t_out_item               pending[$];
        int                      errors;

        function new();
            regs.enable       = 1'b0;
            regs.gate_time_ms = GATE_BITS'(50);
            regs.low_min_hz   = '0;
            regs.low_max_hz   = HZ_BITS'(4000);
            regs.high_min_hz  = HZ_BITS'(6000);
            regs.high_max_hz  = HZ_BITS'(12000);
            pulse_total       = '0;
            elapsed_us        = '0;
            errors            = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                     logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_ENABLE:       regs.enable       = data[0];
                CFG_GATE_TIME_MS: regs.gate_time_ms = data[GATE_BITS-1:0];
                CFG_LOW_MIN_HZ:   regs.low_min_hz   = data[HZ_BITS-1:0];
                CFG_LOW_MAX_HZ:   regs.low_max_hz   = data[HZ_BITS-1:0];
                CFG_HIGH_MIN_HZ:  regs.high_min_hz  = data[HZ_BITS-1:0];
                CFG_HIGH_MAX_HZ:  regs.high_max_hz  = data[HZ_BITS-1:0];
                default: ;
            endcase
        endfunction

        // accumulate one step, queue a result when the gate closes
        function void note_input(t_in_item it);
            longint unsigned el;
            longint unsigned pc;
            longint unsigned gate_us;
            longint unsigned hz;
            longint unsigned lo;
            longint unsigned hi;
            t_out_item       res;
            el = elapsed_us;
            el = el + it.step_us;
            if (el > ((64'd1 << ELAPSED_BITS) - 1))
                el = (64'd1 << ELAPSED_BITS) - 1;
            pc = pulse_total;
            pc = pc + it.edge_count;
            if (pc > COUNT_LIMIT)
                pc = COUNT_LIMIT;
            elapsed_us  = el[ELAPSED_BITS-1:0];
            pulse_total = pc[COUNT_BITS-1:0];
            gate_us = regs.gate_time_ms;
            gate_us = gate_us * US_PER_MS;
            if (!regs.enable || el < gate_us)
                return;
            hz = (el == 0) ? 0 : (pc * US_PER_S) / el;
            if (hz > HZ_MAX)
                hz = HZ_MAX;
            if (it.switch_high) begin
                lo = regs.low_min_hz;
                hi = regs.low_max_hz;
            end else begin
                lo = regs.high_min_hz;
                hi = regs.high_max_hz;
            end
            res.frequency_hz    = hz[HZ_BITS-1:0];
            res.low_band        = it.switch_high;
            res.beacon_detected = (hz >= lo) && (hz <= hi);
            res.switch_level    = it.switch_high;
            pending.push_back(res);
            pulse_total = '0;
            elapsed_us  = '0;
        endfunction

        function void compare_field(string field, logic [HZ_BITS-1:0] want,
                                    logic [HZ_BITS-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hz %0d band %0b",
                         $time, got.frequency_hz, got.low_band);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("frequency_hz", want.frequency_hz, got.frequency_hz);
            compare_field("low_band", HZ_BITS'(want.low_band), HZ_BITS'(got.low_band));
            compare_field("beacon_detected", HZ_BITS'(want.beacon_detected),
                          HZ_BITS'(got.beacon_detected));
            compare_field("switch_level", HZ_BITS'(want.switch_level),
                          HZ_BITS'(got.switch_level));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut hookup, every input known from time zero
    // ------------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      push        = 1'b0;
    logic                      full;
    t_in_item                  i_item      = '0;
    logic                      empty;
    logic                      pop         = 1'b0;
    t_out_item                 o_item;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    band_scoreboard sb;

    gated_frequency_band_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // result side: pop drops at random per cycle while stalling is on
    always @(negedge i_clk) begin
        pop = i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: everything sampled at the rising edge, before the dut updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_result(o_item);
            if (push && !full)
                sb.note_input(i_item);
            if (i_cfg_we)
                sb.write_register(i_cfg_index, i_cfg_data);
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL gated_frequency_band_detector");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers, all called on a falling edge
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic apply_settings(input t_cfg c);
        cfg_write(CFG_ENABLE, CFG_DATA_BITS'(c.enable));
        cfg_write(CFG_GATE_TIME_MS, CFG_DATA_BITS'(c.gate_time_ms));
        cfg_write(CFG_LOW_MIN_HZ, c.low_min_hz);
        cfg_write(CFG_LOW_MAX_HZ, c.low_max_hz);
        cfg_write(CFG_HIGH_MIN_HZ, c.high_min_hz);
        cfg_write(CFG_HIGH_MAX_HZ, c.high_max_hz);
    endtask

    // push one item, with random idle cycles ahead of it; push stays high
    // afterwards so back-to-back items see no gap
    task automatic push_step(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push   = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off the sender until every expected item is out, then let the
    // back end settle since gates that emit nothing leave no trace
    task automatic drain_results();
        push = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_in_item make_step(int step, int edges, bit sw);
        t_in_item it;
        it.step_us     = STEP_BITS'(step);
        it.edge_count  = EDGE_BITS'(edges);
        it.switch_high = sw;
        return it;
    endfunction

    function automatic t_cfg make_cfg(bit en, int gate, int lmin, int lmax,
                                      int hmin, int hmax);
        t_cfg c;
        c.enable       = en;
        c.gate_time_ms = GATE_BITS'(gate);
        c.low_min_hz   = HZ_BITS'(lmin);
        c.low_max_hz   = HZ_BITS'(lmax);
        c.high_min_hz  = HZ_BITS'(hmin);
        c.high_max_hz  = HZ_BITS'(hmax);
        return c;
    endfunction

    function automatic t_in_item random_step();
        int      rs;
        int      re;
        t_in_item it;
        rs = $urandom_range(19);
        re = $urandom_range(9);
        if (rs == 0)
            it.step_us = '0;
        else if (rs == 1)
            it.step_us = '1;
        else if (rs == 2)
            it.step_us = STEP_BITS'($urandom_range(0, 15));
        else
            it.step_us = STEP_BITS'($urandom_range(0, 1023));
        if (re == 0)
            it.edge_count = '0;
        else if (re == 1)
            it.edge_count = '1;
        else
            it.edge_count = EDGE_BITS'($urandom_range(0, 15));
        it.switch_high = $urandom_range(1);
        return it;
    endfunction

    // windows mostly around typical rates, sometimes inverted, wide open or
    // made of arbitrary register values
    function automatic void pick_window(output logic [HZ_BITS-1:0] lo,
                                        output logic [HZ_BITS-1:0] hi);
        int          r;
        logic [31:0] a;
        logic [31:0] b;
        r = $urandom_range(9);
        a = $urandom();
        b = $urandom();
        if (r < 6) begin
            lo = HZ_BITS'($urandom_range(0, 15000));
            hi = lo + HZ_BITS'($urandom_range(0, 20000));
        end else if (r == 6) begin
            hi = HZ_BITS'($urandom_range(0, 15000));
            lo = hi + HZ_BITS'($urandom_range(1, 5000));
        end else if (r == 7) begin
            lo = '0;
            hi = HZ_BITS'(HZ_MAX);
        end else begin
            lo = a[HZ_BITS-1:0];
            hi = b[HZ_BITS-1:0];
        end
    endfunction

    function automatic t_cfg random_settings();
        int   rg;
        t_cfg c;
        rg = $urandom_range(9);
        c.enable = ($urandom_range(9) != 0);
        if (rg < 3)
            c.gate_time_ms = '0;
        else if (rg < 7)
            c.gate_time_ms = GATE_BITS'($urandom_range(1, 3));
        else if (rg < 9)
            c.gate_time_ms = GATE_BITS'($urandom_range(4, 31));
        else
            c.gate_time_ms = GATE_BITS'($urandom_range(32, 40));
        pick_window(c.low_min_hz, c.low_max_hz);
        pick_window(c.high_min_hz, c.high_max_hz);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int p;
        int n;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // spare indexes must not disturb any register
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, '1);

        // disabled after reset: edges pile up with no time passing
        repeat (3) push_step(make_step(0, 15, 1'b1));
        drain_results();

        // every step closes a gate, default band windows
        apply_settings(make_cfg(1'b1, 0, 0, 4000, 6000, 12000));
        push_step(make_step(1, 0, 1'b1));      // 45 MHz, clipped to the ceiling
        push_step(make_step(0, 15, 1'b0));     // no elapsed time, reads 0 Hz
        push_step(make_step(1023, 0, 1'b1));   // 0 Hz on the low band lower bound
        push_step(make_step(250, 1, 1'b1));    // exactly the low band upper bound
        push_step(make_step(999, 4, 1'b1));    // just above the low band
        push_step(make_step(500, 3, 1'b0));    // exactly the high band lower bound
        push_step(make_step(1000, 12, 1'b0));  // exactly the high band upper bound
        push_step(make_step(999, 12, 1'b0));   // just above the high band
        push_step(make_step(1, 15, 1'b0));     // fastest single step
        push_step(make_step(1023, 15, 1'b1));
        drain_results();

        // low window inverted, high window spans every register value
        apply_settings(make_cfg(1'b1, 0, 5000, 4000, 0, (1 << HZ_BITS) - 1));
        push_step(make_step(1, 15, 1'b1));
        push_step(make_step(250, 1, 1'b1));
        push_step(make_step(1, 15, 1'b0));
        push_step(make_step(0, 0, 1'b0));
        drain_results();

        // one millisecond gate: the first step stays open, the second closes it
        apply_settings(make_cfg(1'b1, 1, 0, 4000, 4000, 6000));
        push_step(make_step(600, 2, 1'b1));
        push_step(make_step(400, 3, 1'b0));
        push_step(make_step(1023, 0, 1'b1));
        drain_results();

        // random phases, idling pattern rotates: none, sender, receiver, both
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            apply_settings(random_settings());
            for (n = 0; n < PHASE_ITEMS; n++)
                push_step(random_step());
            drain_results();

            if (p == RANDOM_PHASES / 2) begin
                // disabled stretch runs past the gate length, so the gate
                // closes on the first step once the block is enabled
                apply_settings(make_cfg(1'b0, 90, 0, 2000, 1788, 1788));
                for (n = 0; n < SAT_ITEMS; n++)
                    push_step(make_step($urandom_range(900, 1023),
                                        $urandom_range(10, 15), $urandom_range(1)));
                drain_results();
                apply_settings(make_cfg(1'b1, 90, 0, 2000, 1788, 1788));
                repeat (40) push_step(random_step());
                drain_results();
            end
        end

        // drain_results already waited out the back end latency
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS gated_frequency_band_detector");
        else
            $display("FAIL gated_frequency_band_detector");
        $finish;
    end

endmodule
